// File: sv/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// shared types, constants and helpers of the time weighted mean over sd block
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam int unsigned LEVEL_BITS_DEFAULT = 16;
    localparam int unsigned LEVEL_BITS_MAX     = 24;
    localparam int unsigned TIME_W             = 32;
    localparam int unsigned SUM_W              = 64;
    localparam int unsigned CFG_W              = 32;

    localparam logic [31:0] TOTAL_TIME_RESET = 32'd128000;
    localparam logic [31:0] MEAN_LIMIT_RESET = 32'd327680;

    // register indexes
    localparam logic CFG_TOTAL_TIME = 1'b0;
    localparam logic CFG_MEAN_LIMIT = 1'b1;

    // divider step counts: 64 numerator bits plus the fraction shift
    localparam logic [6:0] DIV_MEAN_STEPS  = 7'd80;
    localparam logic [6:0] DIV_MSQ_STEPS   = 7'd96;
    localparam logic [6:0] DIV_RATIO_STEPS = 7'd80;

    localparam logic [63:0] SQRT_FIRST_BIT = 64'h4000_0000_0000_0000;

    typedef struct packed {
        logic [SUM_W-1:0] ws;
        logic [SUM_W-1:0] wss;
    } tws_sums_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DMEAN,
        ST_DMSQ,
        ST_CHECK,
        ST_VAR,
        ST_SQRT,
        ST_DRATIO,
        ST_EMIT
    } tws_state_t;

    function automatic logic [SUM_W-1:0] sat_add64(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

// File: sv/tws_front.sv
// ----------------------------------------------------------------------------
// tws_front
// takes samples, forms the time weighted products and accumulates the sums
// ----------------------------------------------------------------------------
module tws_front
    import tws_pkg::*;
#(
    parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [31:0]       sample_time,
    input  logic [15:0]       sample_level,
    input  logic              last_sample,
    input  logic              q_full,
    output logic              q_push,
    output tws_sums_t         q_data
);

    localparam int unsigned SQ_W   = 2 * LEVEL_BITS;
    localparam int unsigned HALF_W = LEVEL_BITS_MAX;
    localparam int unsigned SQX_W  = 2 * HALF_W;
    localparam int unsigned PP_W   = HALF_W + TIME_W;
    localparam int unsigned P2_W   = PP_W + HALF_W;
    localparam int unsigned P1_W   = LEVEL_BITS + TIME_W;

    logic [TIME_W-1:0]     prev_time_reg;
    logic [LEVEL_BITS-1:0] prev_level_reg;
    logic [SQ_W-1:0]       prev_sq_reg;
    logic                  pa_valid_reg;
    logic                  pa_last_reg;
    logic [SUM_W-1:0]      pa_p1_reg;
    logic [PP_W-1:0]       pa_lo_reg;
    logic [PP_W-1:0]       pa_hi_reg;
    logic [SUM_W-1:0]      ws_reg;
    logic [SUM_W-1:0]      wss_reg;

    logic [39:0]           lvl_ext;
    logic [LEVEL_BITS-1:0] lvl;
    logic [TIME_W-1:0]     dt;
    logic [SQX_W-1:0]      sq_ext;
    logic [P1_W-1:0]       p1_full;
    logic [PP_W-1:0]       pp_lo;
    logic [PP_W-1:0]       pp_hi;
    logic [P2_W-1:0]       p2_full;
    logic [SUM_W-1:0]      p1;
    logic [SUM_W-1:0]      p2;
    logic                  accept;
    logic                  advance;
    logic [SUM_W-1:0]      ws_next;
    logic [SUM_W-1:0]      wss_next;

    assign lvl_ext  = 40'(sample_level);
    assign lvl      = lvl_ext[LEVEL_BITS-1:0];
    assign dt       = (sample_time >= prev_time_reg) ? (sample_time - prev_time_reg) : '0;
    assign p1_full  = P1_W'(prev_level_reg) * P1_W'(dt);
    assign p1       = SUM_W'(p1_full);

    // level squared times dt in two halves of the square, joined in the next stage
    assign sq_ext   = SQX_W'(prev_sq_reg);
    assign pp_lo    = PP_W'(sq_ext[HALF_W-1:0]) * PP_W'(dt);
    assign pp_hi    = PP_W'(sq_ext[SQX_W-1:HALF_W]) * PP_W'(dt);
    assign p2_full  = {pa_hi_reg, {HALF_W{1'b0}}} + P2_W'(pa_lo_reg);
    assign p2       = (p2_full[P2_W-1:SUM_W] != '0) ? {SUM_W{1'b1}} : p2_full[SUM_W-1:0];

    // a last sample waits in the product stage while the queue is full
    assign in_stall = pa_valid_reg && pa_last_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign advance  = pa_valid_reg && !in_stall;

    assign ws_next  = sat_add64(ws_reg, pa_p1_reg);
    assign wss_next = sat_add64(wss_reg, p2);

    assign q_push     = advance && pa_last_reg;
    assign q_data.ws  = ws_next;
    assign q_data.wss = wss_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg  <= '0;
            prev_level_reg <= '0;
            prev_sq_reg    <= '0;
            pa_valid_reg   <= 1'b0;
            pa_last_reg    <= 1'b0;
            ws_reg         <= '0;
            wss_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                pa_valid_reg <= 1'b1;
                pa_last_reg  <= last_sample;
                if (last_sample)
                begin
                    prev_time_reg  <= '0;
                    prev_level_reg <= '0;
                    prev_sq_reg    <= '0;
                end
                else
                begin
                    prev_time_reg  <= sample_time;
                    prev_level_reg <= lvl;
                    prev_sq_reg    <= SQ_W'(lvl) * SQ_W'(lvl);
                end
            end
            else if (advance)
            begin
                pa_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                if (pa_last_reg)
                begin
                    ws_reg  <= '0;
                    wss_reg <= '0;
                end
                else
                begin
                    ws_reg  <= ws_next;
                    wss_reg <= wss_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pa_p1_reg <= p1;
            pa_lo_reg <= pp_lo;
            pa_hi_reg <= pp_hi;
        end
    end

endmodule

// File: sv/tws_queue.sv
// ----------------------------------------------------------------------------
// tws_queue
// two entry fifo of finished run sums between front and back
// ----------------------------------------------------------------------------
module tws_queue
    import tws_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tws_sums_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      valid,
    output tws_sums_t pop_data
);

    tws_sums_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: sv/tws_back.sv
// ----------------------------------------------------------------------------
// tws_back
// divides the sums, takes the square root and forms mean over sd
// ----------------------------------------------------------------------------
module tws_back
    import tws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] total_time,
    input  logic [31:0] mean_limit,
    input  logic        q_valid,
    input  tws_sums_t   q_data,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] snr_ratio,
    output logic        rejected
);

    tws_state_t  state_reg;
    tws_state_t  state_next;

    logic [63:0] num_reg;
    logic [63:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic        sat_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] wss_reg;
    logic [63:0] mean_reg;
    logic [63:0] msq_reg;
    logic [63:0] sqm_reg;
    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [31:0] snr_reg;
    logic        rej_reg;
    logic        out_valid_reg;
    logic [31:0] out_snr_reg;
    logic        out_rej_reg;

    logic [32:0] rsh;
    logic        ge;
    logic [32:0] rdiff;
    logic        div_last;
    logic [63:0] div_result;
    logic [63:0] sq_sum;
    logic        sq_ge;
    logic        mean_bad;
    logic        emit_load;

    // restoring divider, one quotient bit a cycle
    assign rsh        = {rem_reg, num_reg[63]};
    assign ge         = (rsh >= {1'b0, den_reg});
    assign rdiff      = rsh - {1'b0, den_reg};
    assign div_last   = (cnt_reg == 7'd1);
    assign div_result = (sat_reg || quo_reg[63]) ? {64{1'b1}} : {quo_reg[62:0], ge};

    assign sq_sum   = res_reg + bit_reg;
    assign sq_ge    = (v_reg >= sq_sum);
    assign mean_bad = (mean_reg == '0) || (mean_reg > 64'(mean_limit));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (q_valid) state_next = ST_DMEAN;
            ST_DMEAN:  if (div_last) state_next = ST_DMSQ;
            ST_DMSQ:   if (div_last) state_next = ST_CHECK;
            ST_CHECK:  state_next = mean_bad ? ST_EMIT : ST_VAR;
            ST_VAR:    state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (bit_reg == '0)
                    state_next = (res_reg == '0) ? ST_EMIT : ST_DRATIO;
            end
            ST_DRATIO: if (div_last) state_next = ST_EMIT;
            ST_EMIT:   if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        emit_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: q_pop     = q_valid;
            ST_EMIT: emit_load = !out_valid_reg || !out_stall;
            default:
            begin
                q_pop     = 1'b0;
                emit_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                num_reg <= q_data.ws;
                wss_reg <= q_data.wss;
                quo_reg <= '0;
                rem_reg <= '0;
                sat_reg <= 1'b0;
                cnt_reg <= DIV_MEAN_STEPS;
                den_reg <= (total_time == '0) ? 32'd1 : total_time;
            end
            ST_DMEAN, ST_DMSQ, ST_DRATIO:
            begin
                if (div_last)
                begin
                    quo_reg <= '0;
                    rem_reg <= '0;
                    sat_reg <= 1'b0;
                    num_reg <= wss_reg;
                    cnt_reg <= DIV_MSQ_STEPS;
                    if (state_reg == ST_DMEAN)
                        mean_reg <= div_result;
                    else if (state_reg == ST_DMSQ)
                        msq_reg <= div_result;
                    else
                    begin
                        snr_reg <= (div_result[63:32] != '0) ? 32'hFFFF_FFFF
                                                             : div_result[31:0];
                        rej_reg <= 1'b0;
                    end
                end
                else
                begin
                    num_reg <= {num_reg[62:0], 1'b0};
                    quo_reg <= {quo_reg[62:0], ge};
                    rem_reg <= ge ? rdiff[31:0] : rsh[31:0];
                    sat_reg <= sat_reg || quo_reg[63];
                    cnt_reg <= cnt_reg - 7'd1;
                end
            end
            ST_CHECK:
            begin
                // an accepted mean is below 2^32, so its square fits 64 bits
                sqm_reg <= 64'(mean_reg[31:0]) * 64'(mean_reg[31:0]);
                snr_reg <= '0;
                rej_reg <= 1'b1;
            end
            ST_VAR:
            begin
                v_reg   <= (msq_reg > sqm_reg) ? (msq_reg - sqm_reg) : '0;
                res_reg <= '0;
                bit_reg <= SQRT_FIRST_BIT;
            end
            ST_SQRT:
            begin
                if (bit_reg != '0)
                begin
                    if (sq_ge)
                    begin
                        v_reg   <= v_reg - sq_sum;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
                else
                begin
                    num_reg <= {32'd0, mean_reg[31:0]};
                    den_reg <= res_reg[31:0];
                    quo_reg <= '0;
                    rem_reg <= '0;
                    sat_reg <= 1'b0;
                    cnt_reg <= DIV_RATIO_STEPS;
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    out_snr_reg <= snr_reg;
                    out_rej_reg <= rej_reg;
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign snr_ratio = out_snr_reg;
    assign rejected  = out_rej_reg;

endmodule

// File: sv/time_weighted_mean_over_sd_core.sv
// ----------------------------------------------------------------------------
// time_weighted_mean_over_sd_core
// time weighted signal to noise ratio of a sampled trajectory
// ----------------------------------------------------------------------------
// the input channel carries (sample_time, sample_level, last_sample) requests;
// a request moves on a rising edge with in_valid high and in_stall low
// one sample request is taken every cycle while in_stall is low; its level is
// weighted by the time to the next sample, registered in the product stage and
// then added into saturating sums; a last_sample request closes the run: the
// sums go to a two entry queue and the back end works one run at a time with a
// shared bit serial divider for the mean, the mean square and the ratio, and a
// 32 step square root; a rejected mean skips the square root and ratio divide
// the front keeps taking samples of the next run while the back end works;
// in_stall rises only when a last sample finds the queue full
// one result request per run leaves on out_valid/out_stall; while out_stall
// is high the result holds and the back end waits with the next one
// the user writes registers through cfg_we/cfg_index/cfg_data only while idle;
// the block itself does not enforce this
// reset clears the run sums and loads total_time and mean_limit defaults
// ----------------------------------------------------------------------------
module time_weighted_mean_over_sd_core
    import tws_pkg::*;
#(
    parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] sample_time,
    input  logic [15:0] sample_level,
    input  logic        last_sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] snr_ratio,
    output logic        rejected
);

    logic [31:0] total_time_reg;
    logic [31:0] mean_limit_reg;

    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;
    tws_sums_t   q_in;
    tws_sums_t   q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_time_reg <= TOTAL_TIME_RESET;
            mean_limit_reg <= MEAN_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TOTAL_TIME: total_time_reg <= cfg_data;
                CFG_MEAN_LIMIT: mean_limit_reg <= cfg_data;
                default:        total_time_reg <= total_time_reg;
            endcase
        end
    end

    tws_front #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_time  (sample_time),
        .sample_level (sample_level),
        .last_sample  (last_sample),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in)
    );

    tws_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    tws_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .total_time (total_time_reg),
        .mean_limit (mean_limit_reg),
        .q_valid    (q_valid),
        .q_data     (q_out),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .snr_ratio  (snr_ratio),
        .rejected   (rejected)
    );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives sample runs into the time weighted snr core and checks every result
// against a local predictor, with random input gaps and random output stalls
// ----------------------------------------------------------------------------
module testbench;
    import tws_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] sample_time;
    logic [15:0] sample_level;
    logic        last_sample;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] snr_ratio;
    logic        rejected;

    time_weighted_mean_over_sd_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_time  (sample_time),
        .sample_level (sample_level),
        .last_sample  (last_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .snr_ratio    (snr_ratio),
        .rejected     (rejected)
    );

    typedef struct {
        logic [31:0] ratio;
        logic        rej;
    } snr_result_t;

    typedef struct {
        logic [31:0] t;
        logic [15:0] lvl;
        logic        last;
        logic        fixed;
        logic [31:0] ratio;
        logic        rej;
    } sample_row_t;

    // predictor state
    logic [31:0] pr_total_time;
    logic [31:0] pr_mean_limit;
    logic [31:0] pr_prev_time;
    logic [15:0] pr_prev_level;
    logic        pr_have_prev;
    logic [63:0] pr_ws;
    logic [63:0] pr_wss;

    snr_result_t expected_snr[$];
    sample_row_t directed_rows[$];
    int          error_count;
    int          result_count;
    int          reject_count;
    int          sample_count;
    int          hold_off;
    logic        pressure_done;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [63:0] sum_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] mul_sat(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return (p[127:64] != 0) ? '1 : p[63:0];
    endfunction

    function automatic logic [63:0] scaled_quotient(input logic [63:0] num, input int sh,
                                                    input logic [63:0] den);
        logic [127:0] q;
        q = ({64'd0, num} << sh) / {64'd0, den};
        return (q[127:64] != 0) ? '1 : q[63:0];
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // advance the run state for one request; returns 1 when a result is due
    function automatic bit snr_predict(input logic [31:0] t, input logic [15:0] lvl,
                                       input logic last, output snr_result_t r);
        logic [63:0] dt, den, mean, msq, msq_mean, var_q, sd, ratio;
        if (pr_have_prev)
        begin
            dt = (t >= pr_prev_time) ? 64'(t - pr_prev_time) : 64'd0;
            pr_ws  = sum_sat(pr_ws, mul_sat(64'(pr_prev_level), dt));
            pr_wss = sum_sat(pr_wss, mul_sat(64'(pr_prev_level) * 64'(pr_prev_level), dt));
        end
        if (!last)
        begin
            pr_prev_time = t;
            pr_prev_level = lvl;
            pr_have_prev = 1'b1;
            return 0;
        end
        den  = (pr_total_time == 0) ? 64'd1 : 64'(pr_total_time);
        mean = scaled_quotient(pr_ws, 16, den);
        msq  = scaled_quotient(pr_wss, 32, den);
        pr_prev_time = 0;
        pr_prev_level = 0;
        pr_have_prev = 0;
        pr_ws = 0;
        pr_wss = 0;
        r.ratio = 0;
        r.rej = 1'b1;
        if (mean == 0 || mean > 64'(pr_mean_limit)) return 1;
        msq_mean = mean * mean;
        var_q = (msq > msq_mean) ? msq - msq_mean : 64'd0;
        sd = root_floor(var_q);
        if (sd == 0) return 1;
        ratio = (mean << 16) / sd;
        r.ratio = (ratio > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ratio[31:0];
        r.rej = 1'b0;
        return 1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TOTAL_TIME) pr_total_time = val;
        else pr_mean_limit = val;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_snr.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic send_sample(input logic [31:0] t, input logic [15:0] lvl, input logic last);
        snr_result_t r;
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_time <= t;
        sample_level <= lvl;
        last_sample <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        // accepted at this edge
        if (snr_predict(t, lvl, last, r)) expected_snr.push_back(r);
        sample_count++;
    endtask

    // a well formed run with random content
    task automatic send_run(input int len, input int step_max, input int lvl_max);
        logic [31:0] t;
        t = $urandom_range(0, 1000);
        for (int i = 0; i < len; i++)
        begin
            send_sample(t, 16'($urandom_range(0, lvl_max)), i == len - 1);
            if ($urandom_range(0, 49) == 0) t = t - $urandom_range(0, 200);
            else t = t + $urandom_range(0, step_max);
        end
    endtask

    task automatic add_row(input logic [31:0] t, input logic [15:0] lvl, input logic last,
                           input logic fixed, input logic [31:0] ratio, input logic rej);
        sample_row_t row;
        row.t = t; row.lvl = lvl; row.last = last;
        row.fixed = fixed; row.ratio = ratio; row.rej = rej;
        directed_rows.push_back(row);
    endtask

    // result checker
    always @(posedge clk)
    begin
        snr_result_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_snr.size() == 0)
            begin
                report_mismatch("unexpected result", snr_ratio, 32'd0);
            end
            else
            begin
                w = expected_snr.pop_front();
                result_count++;
                if (w.rej) reject_count++;
                if (snr_ratio !== w.ratio) report_mismatch("snr_ratio", snr_ratio, w.ratio);
                if (rejected !== w.rej) report_mismatch("rejected", 32'(rejected), 32'(w.rej));
            end
        end
    end

    // receiver stalls, with one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_stall <= 1'b1;
        end
        else if (!pressure_done && result_count == 5)
        begin
            pressure_done <= 1'b1;
            hold_off <= 3000;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 3)
        begin
            hold_off <= $urandom_range(1, 30);
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < 25);
    end

    initial
    begin
        snr_result_t r;
        int n;
        error_count = 0; result_count = 0; reject_count = 0; sample_count = 0;
        hold_off = 0; pressure_done = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = CFG_TOTAL_TIME; cfg_data = 0;
        in_valid = 1'b0; sample_time = 0; sample_level = 0; last_sample = 0;
        pr_total_time = TOTAL_TIME_RESET; pr_mean_limit = MEAN_LIMIT_RESET;
        pr_prev_time = 0; pr_prev_level = 0; pr_have_prev = 0; pr_ws = 0; pr_wss = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, reset registers
        add_row(32'd100, 16'd3, 1'b1, 1'b1, 32'd0, 1'b1);          // empty run
        add_row(32'd0, 16'd4, 1'b0, 1'b0, 0, 0);                   // constant level: sd 0
        add_row(32'd128000, 16'd9, 1'b1, 1'b1, 32'd0, 1'b1);
        add_row(32'd0, 16'd2, 1'b0, 1'b0, 0, 0);                   // mixed levels
        add_row(32'd64000, 16'd6, 1'b0, 1'b0, 0, 0);
        add_row(32'd128000, 16'hFFFF, 1'b1, 1'b0, 0, 0);
        add_row(32'd0, 16'hFFFF, 1'b0, 1'b0, 0, 0);                // mean above limit
        add_row(32'd1000, 16'd0, 1'b1, 1'b1, 32'd0, 1'b1);
        add_row(32'd500, 16'd5, 1'b0, 1'b0, 0, 0);                 // backward step
        add_row(32'd100, 16'd1, 1'b0, 1'b0, 0, 0);
        add_row(32'd50100, 16'd7, 1'b0, 1'b0, 0, 0);
        add_row(32'd90000, 16'd0, 1'b1, 1'b0, 0, 0);
        add_row(32'd0, 16'h8000, 1'b0, 1'b0, 0, 0);
        add_row(32'hFFFF_FFFF, 16'h7FFF, 1'b0, 1'b0, 0, 0);        // time extremes
        add_row(32'hFFFF_FFFF, 16'd1, 1'b1, 1'b0, 0, 0);
        foreach (directed_rows[i])
        begin
            send_sample(directed_rows[i].t, directed_rows[i].lvl, directed_rows[i].last);
            if (directed_rows[i].fixed && expected_snr.size() != 0)
            begin
                r = expected_snr[$];
                if (r.ratio !== directed_rows[i].ratio || r.rej !== directed_rows[i].rej)
                    report_mismatch("table row", r.ratio, directed_rows[i].ratio);
            end
        end
        wait_drained();

        // saturation: total_time zero, huge limit, levels and times at the top
        write_reg(CFG_TOTAL_TIME, 32'd0);
        write_reg(CFG_MEAN_LIMIT, 32'hFFFF_FFFF);
        send_sample(32'd0, 16'hFFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, 16'd0, 1'b0);
        send_sample(32'hFFFF_FFFF, 16'd0, 1'b1);
        send_sample(32'd0, 16'd1, 1'b0);
        send_sample(32'd1, 16'd3, 1'b0);
        send_sample(32'd2, 16'd0, 1'b1);
        wait_drained();

        // random phases, each with its own register setting
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin write_reg(CFG_TOTAL_TIME, 32'd128000); write_reg(CFG_MEAN_LIMIT, 32'hFFFF_FFFF); end
                1: begin write_reg(CFG_TOTAL_TIME, 32'hFFFF_FFFF); write_reg(CFG_MEAN_LIMIT, 32'd0); end
                2: begin write_reg(CFG_TOTAL_TIME, 32'd1); write_reg(CFG_MEAN_LIMIT, 32'hFFFF_FFFF); end
                default: begin
                    write_reg(CFG_TOTAL_TIME, $urandom());
                    write_reg(CFG_MEAN_LIMIT, $urandom());
                end
            endcase
            n = 0;
            while (n < 260)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise: random fields, any bit pattern
                    send_sample($urandom(), 16'($urandom()), $urandom_range(0, 3) == 0);
                    n++;
                end
                else
                begin
                    int len;
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(2, 8);
                    send_run(len, ($urandom_range(0, 3) == 0) ? 32'hFFFF : 3000,
                             ($urandom_range(0, 3) == 0) ? 65535 : 40);
                    n += len;
                end
            end
            // sender pauses until all results are back
            wait_drained();
        end

        $display("covered %0d samples, %0d results (%0d rejected), incl. long output hold-off",
                 sample_count, result_count, reject_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
